// ===== sv/bde_pkg.sv =====
// Shared types and constants for the button debounce and encoder event block.
package bde_pkg;

  localparam int unsigned NUM_BUTTONS = 7;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned RUN_BITS    = 16;
  localparam int unsigned CFG_IDX_BITS  = 8;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_BUTTON_ENABLE = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENCODER_EN    = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUEUE_MODE    = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE      = 8'd3;

  // Encoder direction codes
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_PLUS  = 2'd1;
  localparam logic [1:0] DIR_MINUS = 2'd2;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] button_levels;
    logic [COUNT_BITS-1:0]  encoder_count;
    logic [NUM_BUTTONS-1:0] clear_mask;
  } in_item_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] press_events;
    logic [NUM_BUTTONS-1:0] pending_flags;
    logic [NUM_BUTTONS-1:0] query_hits;
    logic [1:0]             encoder_dir;
  } out_item_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] button_enable_mask;
    logic                   encoder_enable;
    logic                   queue_mode;
    logic [RUN_BITS-1:0]    settle_count;
  } cfg_t;

endpackage

// ===== sv/button_debounce_encoder_events_top.sv =====
// Top level: configuration registers, debounce lanes, merge, encoder and output register.
// Each input transfer loads its result into the output register.
// One item per cycle unless stalled; enabled lanes and encoder step in the transfer cycle.
// The input stalls only while a held result is stalled downstream.
// Reset (asynchronous, active low) clears all counters, flags and the encoder history
// and loads the register defaults: all buttons enabled, encoder on, queue mode, 4 samples.
module button_debounce_encoder_events_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bde_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bde_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bde_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bde_pkg::out_item_t                out_data_o
);
  import bde_pkg::*;

  cfg_t      cfg_q;
  out_item_t out_q, out_d;
  logic      out_valid_q;
  logic      in_xfer;
  logic [NUM_BUTTONS-1:0] press;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.button_enable_mask <= {NUM_BUTTONS{1'b1}};
      cfg_q.encoder_enable     <= 1'b1;
      cfg_q.queue_mode         <= 1'b1;
      cfg_q.settle_count       <= RUN_BITS'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BUTTON_ENABLE: cfg_q.button_enable_mask <= cfg_wdata_i[NUM_BUTTONS-1:0];
        CFG_ENCODER_EN:    cfg_q.encoder_enable     <= cfg_wdata_i[0];
        CFG_QUEUE_MODE:    cfg_q.queue_mode         <= cfg_wdata_i[0];
        CFG_DEBOUNCE:      cfg_q.settle_count       <= cfg_wdata_i[RUN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // One debounce lane per button
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    bde_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (in_xfer && cfg_q.button_enable_mask[i]),
      .level_i   (in_data_i.button_levels[i]),
      .samples_i (cfg_q.settle_count),
      .press_o   (press[i])
    );
  end

  bde_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_xfer),
    .queue_mode_i (cfg_q.queue_mode),
    .press_i      (press),
    .clear_mask_i (in_data_i.clear_mask),
    .events_o     (out_d.press_events),
    .flags_o      (out_d.pending_flags),
    .hits_o       (out_d.query_hits)
  );

  bde_encoder u_encoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_xfer),
    .enable_i (cfg_q.encoder_enable),
    .count_i  (in_data_i.encoder_count),
    .dir_o    (out_d.encoder_dir)
  );

  // Output register: load on input transfer, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  a_flag_mode_no_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !cfg_q.queue_mode |=> out_q.press_events == '0)
    else $error("press events reported in flag mode");

  a_encoder_off_no_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !cfg_q.encoder_enable |=> out_q.encoder_dir == DIR_NONE)
    else $error("encoder direction reported while disabled");

  a_stalled_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result lost or changed");

  a_hits_within_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (out_q.query_hits & ~$past(in_data_i.clear_mask)) == '0)
    else $error("query hit outside clear mask");
`endif

endmodule

// ===== sv/bde_lane.sv =====
// One debounce lane: run counters and arm stage of a single button.
module bde_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         level_i,
  input  logic [bde_pkg::RUN_BITS-1:0] samples_i,
  output logic                         press_o
);
  import bde_pkg::*;

  logic [RUN_BITS-1:0] high_run_q, high_run_d;
  logic [RUN_BITS-1:0] low_run_q, low_run_d;
  logic                armed_q, armed_d;

  // Advance the saturating runs and the arm stage for this sample
  always_comb begin
    if (level_i) begin
      high_run_d = (high_run_q == RUN_MAX) ? high_run_q : high_run_q + 1'b1;
      low_run_d  = '0;
    end else begin
      low_run_d  = (low_run_q == RUN_MAX) ? low_run_q : low_run_q + 1'b1;
      high_run_d = '0;
    end
    armed_d = armed_q;
    press_o = 1'b0;
    if (!armed_q) begin
      if (high_run_d >= samples_i) armed_d = 1'b1;
    end else if (low_run_d >= samples_i) begin
      armed_d = 1'b0;
      press_o = step_i;
    end
  end

  // Hold state unless this lane takes a sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_run_q <= '0;
      low_run_q  <= '0;
      armed_q    <= 1'b0;
    end else if (step_i) begin
      high_run_q <= high_run_d;
      low_run_q  <= low_run_d;
      armed_q    <= armed_d;
    end
  end

endmodule

// ===== sv/bde_encoder.sv =====
// Encoder direction from the current count against the last recorded one.
module bde_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           enable_i,
  input  logic [bde_pkg::COUNT_BITS-1:0] count_i,
  output logic [1:0]                     dir_o
);
  import bde_pkg::*;

  logic [COUNT_BITS-1:0] last_count_q;
  logic                  seen_q;

  // Compare with the last count once one has been recorded
  always_comb begin
    dir_o = DIR_NONE;
    if (enable_i && seen_q) begin
      if (count_i > last_count_q)      dir_o = DIR_PLUS;
      else if (count_i < last_count_q) dir_o = DIR_MINUS;
    end
  end

  // Record the count on every enabled transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      seen_q       <= 1'b0;
    end else if (step_i && enable_i) begin
      last_count_q <= count_i;
      seen_q       <= 1'b1;
    end
  end

endmodule

// ===== sv/bde_merge.sv =====
// Merge of lane presses into the event mask or the sticky flags.
module bde_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic                            queue_mode_i,
  input  logic [bde_pkg::NUM_BUTTONS-1:0] press_i,
  input  logic [bde_pkg::NUM_BUTTONS-1:0] clear_mask_i,
  output logic [bde_pkg::NUM_BUTTONS-1:0] events_o,
  output logic [bde_pkg::NUM_BUTTONS-1:0] flags_o,
  output logic [bde_pkg::NUM_BUTTONS-1:0] hits_o
);
  import bde_pkg::*;

  logic [NUM_BUTTONS-1:0] sticky_q, sticky_d;

  // Query and clear first, then set from presses in flag mode
  always_comb begin
    hits_o   = sticky_q & clear_mask_i;
    events_o = queue_mode_i ? press_i : '0;
    sticky_d = (sticky_q & ~clear_mask_i) | (queue_mode_i ? '0 : press_i);
    flags_o  = sticky_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_q <= '0;
    end else if (step_i) begin
      sticky_q <= sticky_d;
    end
  end

endmodule

// ===== tb/tb_button_debounce_encoder_events_top.sv =====
// Self-checking testbench for the button debounce and encoder event block.
module tb_button_debounce_encoder_events_top;
  import bde_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_TICKS  = 16;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_TICKS = 76;

  localparam logic [NUM_BUTTONS-1:0] ALL_BUTTONS  = '1;
  localparam logic [NUM_BUTTONS-1:0] HOLD_PATTERN = 7'h55;

  // Indexes past the register file, writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 8'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_IDX   = 8'hFF;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  // One row of the directed table: a register write or a sample tick
  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_val;
    in_item_t                 tick;
    logic                     typed;
    out_item_t                want;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  in_item_t                 in_data_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  out_item_t                out_data_o;

  // Shadow of the block's registers and per-button debounce state
  logic [NUM_BUTTONS-1:0] btn_en_q;
  logic                   enc_en_q;
  logic                   queue_mode_q;
  logic [RUN_BITS-1:0]    samples_q;
  logic [RUN_BITS-1:0]    high_run [NUM_BUTTONS];
  logic [RUN_BITS-1:0]    low_run  [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] armed_q;
  logic [NUM_BUTTONS-1:0] flags_q;
  logic [COUNT_BITS-1:0]  last_count_q;
  logic                   count_seen_q;

  out_item_t   expected_reports [$];
  stim_row_t   directed_rows [$];
  int          fault_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;

  // Random walk state for the generated sample stream
  logic [NUM_BUTTONS-1:0] held_levels = '1;
  logic [COUNT_BITS-1:0]  enc_pos = '0;

  button_debounce_encoder_events_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Length of one idle stretch: mostly short, now and then long
  function automatic int unsigned idle_span();
    return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Compute one tick's report: query and clear, debounce, then encoder direction
  function automatic out_item_t predict_tick(input in_item_t tick);
    out_item_t res;
    int        b;
    res = '0;
    res.query_hits = flags_q & tick.clear_mask;
    flags_q = flags_q & ~tick.clear_mask;
    for (b = 0; b < NUM_BUTTONS; b++) begin
      if (btn_en_q[b]) begin
        if (tick.button_levels[b]) begin
          if (high_run[b] != RUN_MAX) high_run[b] = high_run[b] + 1'b1;
          low_run[b] = '0;
        end else begin
          if (low_run[b] != RUN_MAX) low_run[b] = low_run[b] + 1'b1;
          high_run[b] = '0;
        end
        if (!armed_q[b]) begin
          if (high_run[b] >= samples_q) armed_q[b] = 1'b1;
        end else if (low_run[b] >= samples_q) begin
          armed_q[b] = 1'b0;
          if (queue_mode_q) res.press_events[b] = 1'b1;
          else flags_q[b] = 1'b1;
        end
      end
    end
    res.pending_flags = flags_q;
    res.encoder_dir = DIR_NONE;
    if (enc_en_q) begin
      if (count_seen_q && tick.encoder_count > last_count_q) res.encoder_dir = DIR_PLUS;
      else if (count_seen_q && tick.encoder_count < last_count_q) res.encoder_dir = DIR_MINUS;
      last_count_q = tick.encoder_count;
      count_seen_q = 1'b1;
    end
    return res;
  endfunction

  // Generate a sample: held levels with rare toggles and one-tick glitches
  function automatic in_item_t next_tick();
    in_item_t               t;
    int unsigned            roll;
    logic [NUM_BUTTONS-1:0] flip;
    logic [COUNT_BITS-1:0]  step;
    roll = $urandom_range(99);
    flip = NUM_BUTTONS'($urandom());
    if (roll < 10) held_levels = held_levels ^ flip;
    t.button_levels = held_levels;
    if (roll >= 90) t.button_levels = held_levels ^ flip;
    roll = $urandom_range(99);
    step = COUNT_BITS'($urandom_range(1, 4));
    if (roll >= 85) enc_pos = COUNT_BITS'($urandom());
    else if (roll >= 40) enc_pos = $urandom_range(1) ? enc_pos + step : enc_pos - step;
    t.encoder_count = enc_pos;
    roll = $urandom_range(99);
    if (roll < 60) t.clear_mask = '0;
    else if (roll < 85) t.clear_mask = NUM_BUTTONS'($urandom());
    else t.clear_mask = ALL_BUTTONS;
    return t;
  endfunction

  task automatic add_tick(input logic [NUM_BUTTONS-1:0] lv, input logic [COUNT_BITS-1:0] cnt,
                          input logic [NUM_BUTTONS-1:0] clr);
    stim_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.tick = {lv, cnt, clr};
    directed_rows.push_back(r);
  endtask

  task automatic add_check(input logic [NUM_BUTTONS-1:0] lv, input logic [COUNT_BITS-1:0] cnt,
                           input logic [NUM_BUTTONS-1:0] clr, input out_item_t want);
    stim_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.tick = {lv, cnt, clr};
    r.typed = 1'b1;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  task automatic add_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    directed_rows.push_back(r);
  endtask

  // Drive one register write and mirror it in the shadow copy
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    unique case (idx)
      CFG_BUTTON_ENABLE: btn_en_q = val[NUM_BUTTONS-1:0];
      CFG_ENCODER_EN:    enc_en_q = val[0];
      CFG_QUEUE_MODE:    queue_mode_q = val[0];
      CFG_DEBOUNCE:      samples_q = val[RUN_BITS-1:0];
      default: ;
    endcase
  endtask

  // Hold off the sender until every pending report has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_reports.size() != 0);
  endtask

  // Offer one sample, wait for its transfer, then queue its report
  task automatic push_item(input in_item_t tick, input logic typed, input out_item_t typed_val);
    int unsigned gap;
    out_item_t   predicted;
    gap = (calm || $urandom_range(99) < 70) ? 0 : idle_span();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= tick;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predicted = predict_tick(tick);
    expected_reports.push_back(typed ? typed_val : predicted);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  // Stall the result side in random bursts
  always @(posedge clk_i) begin
    if (stall_left == 0 && !calm && $urandom_range(99) < 8) stall_left = idle_span();
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Compare each result transfer against the oldest queued report
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_reports.size() == 0) begin
        $error("report %h arrived with none outstanding", out_data_o);
        fault_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("press_events", want.press_events, out_data_o.press_events);
        check_field("pending_flags", want.pending_flags, out_data_o.pending_flags);
        check_field("query_hits", want.query_hits, out_data_o.query_hits);
        check_field("encoder_dir", want.encoder_dir, out_data_o.encoder_dir);
      end
    end
  end

  // End the run when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $error("no transfer for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned              p;
    int unsigned              n;
    logic [CFG_DATA_BITS-1:0] wd;
    in_item_t                 tick;
    stim_row_t                row;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;

    // Register defaults and cleared history, as after reset
    btn_en_q = ALL_BUTTONS;
    enc_en_q = 1'b1;
    queue_mode_q = 1'b1;
    samples_q = 16'd4;
    foreach (high_run[b]) begin
      high_run[b] = '0;
      low_run[b] = '0;
    end
    armed_q = '0;
    flags_q = '0;
    last_count_q = '0;
    count_seen_q = 1'b0;

    // Defaults: recording tick, then direction from the count extremes
    add_check(7'h00, 16'h0000, 7'h00, {7'h00, 7'h00, 7'h00, DIR_NONE});
    add_check(7'h7F, 16'hFFFF, 7'h7F, {7'h00, 7'h00, 7'h00, DIR_PLUS});
    add_check(7'h7F, 16'h0000, 7'h00, {7'h00, 7'h00, 7'h00, DIR_MINUS});
    add_check(7'h7F, 16'h0000, 7'h00, {7'h00, 7'h00, 7'h00, DIR_NONE});
    // Fourth high sample arms, fourth low sample reports the press
    add_tick(7'h7F, 16'h0001, 7'h00);
    add_tick(7'h00, 16'h0001, 7'h00);
    add_tick(7'h00, 16'h0001, 7'h00);
    add_tick(7'h00, 16'h0001, 7'h00);
    add_tick(7'h00, 16'h0001, 7'h00);
    // Flag mode with one-sample debounce: set, query, clear in the press tick
    add_write(CFG_QUEUE_MODE, 16'h0000);
    add_write(CFG_DEBOUNCE, 16'h0001);
    add_tick(7'h7F, 16'h0001, 7'h00);
    add_tick(7'h00, 16'h0001, 7'h00);
    add_tick(7'h7F, 16'h0001, 7'h7F);
    add_tick(7'h00, 16'h0001, 7'h7F);
    // Flags survive the return to queue mode
    add_write(CFG_QUEUE_MODE, 16'hFFFF);
    add_tick(7'h7F, 16'h0001, 7'h00);
    add_tick(7'h00, 16'h0001, 7'h55);
    // Encoder off keeps the last count
    add_write(CFG_ENCODER_EN, 16'hFFFE);
    add_tick(7'h00, 16'h1234, 7'h00);
    add_tick(7'h00, 16'h0000, 7'h7F);
    add_write(CFG_ENCODER_EN, 16'h0001);
    add_tick(7'h2A, 16'h0002, 7'h00);
    // Disabled buttons stay frozen
    add_write(CFG_BUTTON_ENABLE, 16'hFF2A);
    add_tick(7'h7F, 16'hFFFF, 7'h00);
    add_tick(7'h00, 16'h8000, 7'h00);
    // Zero samples: arm on one tick and fire on the next, whatever the level
    add_write(CFG_DEBOUNCE, 16'h0000);
    add_tick(7'h00, 16'h8000, 7'h00);
    add_tick(7'h00, 16'h8000, 7'h00);
    add_tick(7'h7F, 16'h7FFF, 7'h00);
    add_write(CFG_UNUSED_IDX, 16'hFFFF);
    add_write(CFG_LAST_IDX, 16'h0000);
    add_tick(7'h55, 16'h7FFF, 7'h00);
    add_write(CFG_BUTTON_ENABLE, 16'hFFFF);
    add_write(CFG_DEBOUNCE, 16'hFFFF);
    add_tick(7'h7F, 16'hFFFF, 7'h2A);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        wait_drained();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        cfg_we_i <= 1'b0;
        push_item(row.tick, row.typed, row.want);
      end
    end

    // Random phases, each with its own register settings
    for (p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      calm = (p % 4 == 3);
      wd = CFG_DATA_BITS'($urandom());
      if (p == 2) wd[NUM_BUTTONS-1:0] = '0;
      else if (p == 4) wd[NUM_BUTTONS-1:0] = ALL_BUTTONS;
      write_reg(CFG_BUTTON_ENABLE, wd);
      wd = CFG_DATA_BITS'($urandom());
      if (p == 6) wd[0] = 1'b0;
      write_reg(CFG_ENCODER_EN, wd);
      wd = CFG_DATA_BITS'($urandom());
      wd[0] = p[0];
      write_reg(CFG_QUEUE_MODE, wd);
      unique case (p)
        1: wd = RUN_MAX;
        3: wd = '0;
        7: wd = 16'd1;
        default: wd = CFG_DATA_BITS'($urandom_range(1, 6));
      endcase
      write_reg(CFG_DEBOUNCE, wd);
      cfg_we_i <= 1'b0;
      for (n = 0; n < PHASE_TICKS; n++) begin
        if ($urandom_range(49) == 0) wait_drained();
        push_item(next_tick(), 1'b0, '0);
      end
    end

    // Hold one level pattern for a stretch under the longest debounce
    wait_drained();
    calm = 1'b0;
    write_reg(CFG_BUTTON_ENABLE, 16'h007F);
    write_reg(CFG_QUEUE_MODE, 16'h0001);
    write_reg(CFG_DEBOUNCE, RUN_MAX);
    cfg_we_i <= 1'b0;
    repeat (HOLD_TICKS) begin
      tick = next_tick();
      tick.button_levels = HOLD_PATTERN;
      push_item(tick, 1'b0, '0);
    end
    // Zero samples for one tick: armed buttons fire, the others arm
    wait_drained();
    write_reg(CFG_DEBOUNCE, '0);
    cfg_we_i <= 1'b0;
    push_item(tick, 1'b0, '0);
    // Full count again: short runs neither arm nor fire
    wait_drained();
    write_reg(CFG_DEBOUNCE, RUN_MAX);
    cfg_we_i <= 1'b0;
    push_item(tick, 1'b0, '0);
    // One opposite sample shows which buttons armed
    wait_drained();
    write_reg(CFG_DEBOUNCE, 16'd1);
    cfg_we_i <= 1'b0;
    tick.button_levels = ~HOLD_PATTERN;
    push_item(tick, 1'b0, '0);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bde_pkg.sv
sv/bde_lane.sv
sv/bde_encoder.sv
sv/bde_merge.sv
sv/button_debounce_encoder_events_top.sv
tb/tb_button_debounce_encoder_events_top.sv
